// File: hdl/b2ad_pkg.sv
package b2ad_pkg;

    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 6;
    localparam int MAX_DIGITS  = 10;
    // a 32-bit value never needs more than ten decimal digits
    localparam int WORD_DIGITS = 10;
    localparam int DIGITS_USED = (MAX_DIGITS < WORD_DIGITS) ? MAX_DIGITS : WORD_DIGITS;
    localparam int BCD_W       = 4 * WORD_DIGITS;
    localparam int IDX_W       = $clog2(WORD_DIGITS);
    localparam int CNT_W       = $clog2(VALUE_W);
    localparam int OUT_DATA_W  = 8 * ((CHAR_W + 7) / 8);

    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
    localparam logic [CNT_W-1:0]  LAST_SHIFT = CNT_W'(VALUE_W - 1);

    // controller to datapath
    typedef struct packed {
        logic load;        // capture input word, clear bcd
        logic shift;       // one double dabble step
        logic set_index;   // point at most significant kept digit
        logic step_index;  // move to next lower digit
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic idx_zero;    // current digit is the final one
    } status_t;

endpackage

// File: hdl/b2ad_datapath.sv
module b2ad_datapath (
    input  logic                             clk,
    input  logic [b2ad_pkg::VALUE_W-1:0]     value,
    input  b2ad_pkg::cmd_t                   cmd,
    output b2ad_pkg::status_t                status,
    output logic [b2ad_pkg::CHAR_W-1:0]      digit_char,
    output logic                             last_digit
);
    import b2ad_pkg::*;

    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [BCD_W-1:0]   bcd_adj;
    logic [IDX_W-1:0]   top_idx;
    logic [3:0]         cur_digit;

    // add 3 to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < WORD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    // highest nonzero digit among the kept slots, zero value gives slot 0;
    // when higher digits are dropped every kept slot goes out, leading zeros too
    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < DIGITS_USED; i++)
        begin
            if (bcd_reg[4*i +: 4] != 4'd0)
                top_idx = IDX_W'(i);
        end
        for (int i = DIGITS_USED; i < WORD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] != 4'd0)
                top_idx = IDX_W'(DIGITS_USED - 1);
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        idx_next = idx_reg;
        if (cmd.load)
        begin
            bin_next = value;
            bcd_next = '0;
        end
        else if (cmd.shift)
        begin
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
        end
        if (cmd.set_index)
            idx_next = top_idx;
        else if (cmd.step_index)
            idx_next = idx_reg - IDX_W'(1);
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        idx_reg <= idx_next;
    end

    assign cur_digit       = bcd_reg[4*idx_reg +: 4];
    assign digit_char      = ASCII_ZERO + CHAR_W'(cur_digit);
    assign last_digit      = (idx_reg == '0);
    assign status.idx_zero = (idx_reg == '0);

endmodule

// File: hdl/b2ad_ctrl.sv
module b2ad_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  b2ad_pkg::status_t   status,
    output b2ad_pkg::cmd_t      cmd
);
    import b2ad_pkg::*;

    typedef enum logic [1:0] {
        IDLE,
        CONVERT,
        SCAN,
        EMIT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             s_tready_reg, s_tready_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             in_acc, out_acc;

    assign in_acc  = s_tvalid && s_tready_reg;
    assign out_acc = m_tvalid_reg && m_tready;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        s_tready_next = s_tready_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;
        case (state_reg)
            IDLE:
            begin
                if (in_acc)
                begin
                    cmd.load      = 1'b1;
                    cnt_next      = '0;
                    s_tready_next = 1'b0;
                    state_next    = CONVERT;
                end
            end
            CONVERT:
            begin
                cmd.shift = 1'b1;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_SHIFT)
                    state_next = SCAN;
            end
            SCAN:
            begin
                cmd.set_index = 1'b1;
                m_tvalid_next = 1'b1;
                state_next    = EMIT;
            end
            EMIT:
            begin
                if (out_acc)
                begin
                    cmd.step_index = 1'b1;
                    if (status.idx_zero)
                    begin
                        m_tvalid_next = 1'b0;
                        s_tready_next = 1'b1;
                        state_next    = IDLE;
                    end
                end
            end
            default:
            begin
                state_next    = IDLE;
                s_tready_next = 1'b1;
                m_tvalid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            cnt_reg      <= '0;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            s_tready_reg <= s_tready_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

    // one item at a time: never ready for input while a digit is offered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready_reg && m_tvalid_reg))
        else $error("input ready while output valid");

    // an accepted word starts a full conversion
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == CONVERT) && (cnt_reg == '0) && !s_tready_reg)
        else $error("accept did not start conversion");

    // digits appear only after the scan of a finished conversion
    a_valid_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg) == SCAN)
        else $error("output valid without finished conversion");

    // final digit taken frees the input side
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && status.idx_zero) |=> s_tready_reg && !m_tvalid_reg)
        else $error("block not idle after final digit");

endmodule

// File: hdl/binary_to_ascii_decimal_core.sv
// channel   | direction | tdata                        | tuser | tlast
// ----------+-----------+------------------------------+-------+-----------------------
// s_axis    | in        | [31:0] value                 | none  | none
// m_axis    | out       | [5:0] digit_char, [7:6] zero | none  | last_digit
//
// one word in gives 1 to 10 digit words out, most significant first, no leading zeros
// a word passes through an accept step, 32 serial double dabble shifts and a scan step,
// then gives one digit per cycle while m_tready is high
// rst_n is asynchronous, active low, and returns the block to idle with s_tready high
// a low m_tready holds the current digit word; no new input is taken until the last digit goes
module binary_to_ascii_decimal_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [b2ad_pkg::VALUE_W-1:0]        s_tdata,   // [31:0] value
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [b2ad_pkg::OUT_DATA_W-1:0]     m_tdata,   // [5:0] digit_char, rest zero
    output logic                                m_tlast    // last_digit
);
    import b2ad_pkg::*;

    cmd_t              cmd;
    status_t           status;
    logic [CHAR_W-1:0] digit_char;

    // sequencer: accept, shift count, scan, digit emit
    b2ad_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // binary shifter, bcd digit register and digit pointer
    b2ad_datapath u_dp (
        .clk        (clk),
        .value      (s_tdata),
        .cmd        (cmd),
        .status     (status),
        .digit_char (digit_char),
        .last_digit (m_tlast)
    );

    // pad the character code to a whole byte
    assign m_tdata = OUT_DATA_W'(digit_char);

endmodule

// File: bench/tb_decimal_checker.sv
`timescale 1ns / 100ps

module tb_decimal_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [b2ad_pkg::VALUE_W-1:0]        s_tdata,   // [31:0] value
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [b2ad_pkg::OUT_DATA_W-1:0]     m_tdata,   // [5:0] digit_char, rest zero
    input  logic                                m_tlast,   // last_digit
    output int                                  mismatches,
    output int                                  digits_owed
);

    import b2ad_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last_digit;
    } digit_word_t;

    digit_word_t expected_digits [$];

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // decimal text of one value, least significant digit kept when slots run out
    function automatic void queue_decimal_digits(input logic [VALUE_W-1:0] value);
        logic [3:0]         dec [WORD_DIGITS];
        logic [VALUE_W-1:0] rest;
        int                 count;
        int                 slots;
        digit_word_t        w;
        slots = MAX_DIGITS;
        if (slots < 1)
            slots = 1;
        if (slots > WORD_DIGITS)
            slots = WORD_DIGITS;
        rest  = value;
        count = 0;
        do
        begin
            dec[count] = 4'(rest % 10);
            rest       = rest / 10;
            count++;
        end
        while (rest != 0 && count < slots);
        for (int k = 0; k < count; k++)
        begin
            w.digit_char = ASCII_ZERO + CHAR_W'(dec[count - 1 - k]);
            w.last_digit = (k == count - 1);
            expected_digits.push_back(w);
        end
    endfunction

    always @(posedge clk)
    begin : watch
        digit_word_t w;
        if (rst_n)
        begin
            // results first, then a newly accepted word is queued behind them
            if (m_tvalid && m_tready)
            begin
                if (expected_digits.size() == 0)
                    report_mismatch($sformatf("unexpected digit word tdata=%02h tlast=%b",
                                              m_tdata, m_tlast));
                else
                begin
                    w = expected_digits.pop_front();
                    if (m_tdata[CHAR_W-1:0] !== w.digit_char)
                        report_mismatch($sformatf("digit_char %0d, want %0d",
                                                  m_tdata[CHAR_W-1:0], w.digit_char));
                    if (m_tlast !== w.last_digit)
                        report_mismatch($sformatf("last_digit %b, want %b",
                                                  m_tlast, w.last_digit));
                    if (m_tdata[OUT_DATA_W-1:CHAR_W] !== '0)
                        report_mismatch($sformatf("pad bits of tdata not zero: %02h",
                                                  m_tdata));
                end
            end
            if (s_tvalid && s_tready)
                queue_decimal_digits(s_tdata);
            digits_owed <= expected_digits.size();
        end
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import b2ad_pkg::*;

    localparam int CORNER_WORDS = 22;
    localparam int RANDOM_WORDS = 400;
    // last stretch of the run goes without any idling
    localparam int QUIET_WORDS  = 60;
    // long receiver hold-off, well past one conversion so the input stalls
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_LIMIT  = 20000;
    // longest conversion plus margin, for stray words after the last digit
    localparam int SETTLE_CYCLES = 60;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [VALUE_W-1:0]    s_tdata  = '0;       // [31:0] value
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;             // [5:0] digit_char, rest zero
    logic                  m_tlast;             // last_digit

    int                    mismatches;
    int                    digits_owed;
    int unsigned           words_sent = 0;
    bit                    quiet      = 1'b0;
    logic [VALUE_W-1:0]    corner_values [0:CORNER_WORDS-1];

    binary_to_ascii_decimal_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    tb_decimal_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .digits_owed (digits_owed)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // reset held low from the start, then released once
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // run limit, far beyond the slowest correct run
    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    // half the values are of a chosen digit count, so short and long texts both show up often;
    // the rest full-range words, powers of ten and all-nines runs
    function automatic logic [VALUE_W-1:0] pick_value();
        longint unsigned lo;
        longint unsigned hi;
        int unsigned     n_digits;
        int unsigned     kind;
        kind     = $urandom_range(0, 3);
        n_digits = $urandom_range(1, WORD_DIGITS);
        lo = 1;
        repeat (n_digits - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (n_digits == 1)
            lo = 0;
        if (hi > 64'hFFFF_FFFF)
            hi = 64'hFFFF_FFFF;
        if (kind == 0)
            return $urandom;
        if (kind == 3)
            return VALUE_W'(($urandom_range(0, 1) != 0) ? hi : lo);
        return VALUE_W'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
    endfunction

    // offer one value word, with an occasional burst of idle cycles ahead of it;
    // valid stays high between back-to-back words
    task automatic send_word(input logic [VALUE_W-1:0] value);
        int unsigned idle;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            idle = $urandom_range(1, 19);
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        words_sent++;
    endtask

    // receiver pacing: random stall bursts, one long hold-off early on
    initial
    begin : sink_pacing
        int unsigned stall_left;
        bit          long_hold_done;
        stall_left     = 0;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!long_hold_done && words_sent >= CORNER_WORDS + 20)
            begin
                // sender keeps offering while digits back up
                long_hold_done = 1'b1;
                stall_left     = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int unsigned waited;
        // zero, digit-count boundaries, the 32-bit extremes and alternating bit patterns
        corner_values = '{
            32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd12345,
            32'd100000, 32'd90909090, 32'd999999999, 32'd1000000000, 32'd1000000001,
            32'd1234567890, 32'd2147483647, 32'd2147483648, 32'd4000000000,
            32'd4294967290, 32'd4294967294, 32'd4294967295,
            32'h5555_5555, 32'hAAAA_AAAA
        };
        waited = 0;
        @(posedge rst_n);
        @(posedge clk);

        for (int i = 0; i < CORNER_WORDS; i++)
            send_word(corner_values[i]);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            quiet = (i >= RANDOM_WORDS - QUIET_WORDS);
            send_word(pick_value());
        end
        s_tvalid <= 1'b0;
        // let the owed count take in the last accepted word
        @(posedge clk);

        // drain, then give stray words time to show
        while (digits_owed != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && digits_owed == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
